// File: rtl/hfd_pkg.sv
// ============================================================================
// hfd_pkg: shared types and constants of the hex field decoder
// Character codes, field phases, result status codes and the hex digit decode.
// ============================================================================
package hfd_pkg;

    // Field phase: before the field, after a leading minus, inside the digits.
    // The fourth code is never entered; it falls back to a field start.
    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_MINUS  = 2'd1,
        PH_DIGITS = 2'd2,
        PH_SPARE  = 2'd3
    } phase_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_TERM  = 2'd2,
        ST_OVF   = 2'd3
    } status_t;

    // Number format codes; any code from FMT_S64 up is treated as signed.
    localparam logic [1:0] FMT_U32 = 2'd0;
    localparam logic [1:0] FMT_U64 = 2'd1;
    localparam logic [1:0] FMT_S64 = 2'd2;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned COUNT_W = 5;

    localparam logic [COUNT_W-1:0] LIMIT_U32 = COUNT_W'(8);
    localparam logic [COUNT_W-1:0] LIMIT_64  = COUNT_W'(16);

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] nib;
    } hex_digit_t;

    // Maps an ASCII character to its hex digit value, if it is one.
    function automatic hex_digit_t hex_decode(input logic [CHAR_W-1:0] c);
        hex_digit_t d;
        d.is_hex = 1'b0;
        d.nib    = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d.is_hex = 1'b1;
            d.nib    = 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d.is_hex = 1'b1;
            d.nib    = 4'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d.is_hex = 1'b1;
            d.nib    = 4'(c - 8'h57);
        end
        return d;
    endfunction

endpackage

// File: rtl/hex_field_decoder.sv
// ============================================================================
// hex_field_decoder: streaming hexadecimal number field parser
// Parses one hex number per field from a character stream, one result a field.
// ============================================================================
// Usage:
// The slave stream carries one character per transaction. s_axis_tdata holds
// the character and the expected terminator, s_axis_tuser the number format.
// Terminator and format are sampled only on the first character of a field.
// When a field ends (terminator check, NUL, empty field or signed overflow)
// one transaction leaves on the master stream: the 64-bit value in
// m_axis_tdata and the status code in m_axis_tuser. Characters that do not
// end a field produce no output transaction.
// The result of a finishing character is registered and valid in the cycle
// after it is accepted. Throughput is one character per cycle while
// s_axis_tready is high; the only loop is the field state update (nibble
// decode, shift and insert); the 64-bit negate feeds the result register.
// The result register stays full while the receiver holds m_axis_tready low,
// and the slave side stalls for as long as that result waits, whether or not
// the next character would end a field: s_axis_tready is low exactly while a
// result is held and not being taken. A result taken in a cycle frees the
// slave side in that same cycle, so a ready receiver causes no gap.
// Reset clears the field state to a field start, the held terminator and
// format to zero, and empties the result register.
// ============================================================================
module hex_field_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] ch, [15:8] terminator
    input  logic [1:0]  s_axis_tuser,   // [1:0] num_format
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] value
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    // Field state.
    hfd_pkg::phase_t                  phase_reg, phase_next;
    logic [hfd_pkg::VALUE_W-1:0]      accum_reg, accum_next;
    logic [hfd_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic                             negative_reg, negative_next;
    logic [hfd_pkg::CHAR_W-1:0]       term_reg, term_next;
    logic [1:0]                       format_reg, format_next;

    // Result register.
    logic                             out_valid_reg, out_valid_next;
    logic [hfd_pkg::VALUE_W-1:0]      out_value_reg, out_value_next;
    hfd_pkg::status_t                 out_status_reg, out_status_next;

    logic [hfd_pkg::CHAR_W-1:0]       ch;
    logic [hfd_pkg::CHAR_W-1:0]       term_eff;
    logic [1:0]                       format_eff;
    logic [hfd_pkg::COUNT_W-1:0]      limit;
    hfd_pkg::hex_digit_t              digit;
    logic [hfd_pkg::VALUE_W-1:0]      final_value;
    logic                             in_fire;
    logic                             finish;
    logic [hfd_pkg::VALUE_W-1:0]      fin_value;
    hfd_pkg::status_t                 fin_status;

    assign ch      = s_axis_tdata[7:0];
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // Accept whenever the result register is empty or is emptied this cycle.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;

    // Terminator and format come from the port on a field's first character.
    assign term_eff   = (phase_reg == hfd_pkg::PH_START) ? s_axis_tdata[15:8] : term_reg;
    assign format_eff = (phase_reg == hfd_pkg::PH_START) ? s_axis_tuser : format_reg;
    assign limit      = (format_eff == hfd_pkg::FMT_U32) ? hfd_pkg::LIMIT_U32
                                                         : hfd_pkg::LIMIT_64;
    assign digit      = hfd_pkg::hex_decode(ch);

    // Value on a good terminator: 32-bit format keeps the low word only, and a minus sign negates it.
    always_comb
    begin
        final_value = accum_reg;
        if (format_eff == hfd_pkg::FMT_U32)
        begin
            final_value = {32'd0, accum_reg[31:0]};
        end
        if (negative_reg)
        begin
            final_value = '0 - final_value;
        end
    end

    // Field state update for one character.
    always_comb
    begin
        phase_next    = phase_reg;
        accum_next    = accum_reg;
        count_next    = count_reg;
        negative_next = negative_reg;
        term_next     = term_reg;
        format_next   = format_reg;
        finish        = 1'b0;
        fin_value     = '0;
        fin_status    = hfd_pkg::ST_OK;

        if (phase_reg == hfd_pkg::PH_START)
        begin
            term_next   = s_axis_tdata[15:8];
            format_next = s_axis_tuser;
        end

        case (phase_reg)
            hfd_pkg::PH_START,
            hfd_pkg::PH_MINUS,
            hfd_pkg::PH_DIGITS:
            begin
                if (phase_reg != hfd_pkg::PH_DIGITS && ch == hfd_pkg::CHAR_NUL)
                begin
                    finish     = 1'b1;
                    fin_status = hfd_pkg::ST_EMPTY;
                end
                else if (phase_reg == hfd_pkg::PH_START &&
                         format_eff >= hfd_pkg::FMT_S64 && ch == hfd_pkg::CHAR_MINUS)
                begin
                    negative_next = 1'b1;
                    phase_next    = hfd_pkg::PH_MINUS;
                end
                else if (ch != hfd_pkg::CHAR_NUL && count_reg < limit && digit.is_hex)
                begin
                    if (negative_reg && count_reg == '0 && digit.nib[3])
                    begin
                        finish     = 1'b1;
                        fin_status = hfd_pkg::ST_OVF;
                    end
                    else
                    begin
                        accum_next = {accum_reg[hfd_pkg::VALUE_W-5:0], digit.nib};
                        count_next = count_reg + 1'b1;
                        phase_next = hfd_pkg::PH_DIGITS;
                    end
                end
                else if (ch != term_eff)
                begin
                    finish     = 1'b1;
                    fin_status = hfd_pkg::ST_TERM;
                end
                else
                begin
                    finish    = 1'b1;
                    fin_value = final_value;
                end
            end
            default:
            begin
                phase_next = hfd_pkg::PH_START;
            end
        endcase

        // A finished field rearms the parser; the held terminator and format stay.
        if (finish)
        begin
            phase_next    = hfd_pkg::PH_START;
            accum_next    = '0;
            count_next    = '0;
            negative_next = 1'b0;
        end
    end

    // Result register loads on a finishing character and drains on a take.
    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        if (in_fire && finish)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = fin_value;
            out_status_next = fin_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= hfd_pkg::PH_START;
            accum_reg     <= '0;
            count_reg     <= '0;
            negative_reg  <= 1'b0;
            term_reg      <= '0;
            format_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg    <= phase_next;
                accum_reg    <= accum_next;
                count_reg    <= count_next;
                negative_reg <= negative_next;
                term_reg     <= term_next;
                format_reg   <= format_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_status_reg;

endmodule

// File: rtl/hfd_checker.sv
// ============================================================================
// hfd_checker: port-level checks of the hex field decoder
// Watches both streams and flags results or handshakes that cannot be right.
// ============================================================================
module hfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A stalled result keeps its value and status.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // A stalled character stays on the bus unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
        else $error("stalled character changed");

    // Every error status carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != hfd_pkg::ST_OK |-> m_axis_tdata == '0)
        else $error("error result with nonzero value");

    // A new result follows a character taken at the previous edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !($past(m_axis_tvalid) && !$past(m_axis_tready)) |->
            $past(s_axis_tvalid && s_axis_tready))
        else $error("result without an accepted character");

    // The input side only stalls while a result is held back.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a waiting result");

endmodule

bind hex_field_decoder hfd_checker u_hfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
